// ===== rtl/brf_pkg.sv =====
package brf_pkg;

  localparam int MAX_BURST   = 16;
  localparam int MAX_PATTERN = 8;

  localparam int KIND_W   = 3;
  localparam int DATA_W   = 8;
  localparam int CNT_W    = 5;
  localparam int PAT_W    = 64;
  localparam int PLEN_W   = 4;
  localparam int POS_W    = 10;
  localparam int LVL_W    = 10;
  localparam int QSIZE_W  = 11;
  localparam int QSIZE_HI = 1024;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [APB_AW-3:0] REG_QSIZE = '0;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_FIND    = 3'd3,
    OP_FINDPAT = 3'd4,
    OP_FLUSH   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_BURST,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              ok;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [LVL_W-1:0]  level;
    logic [LVL_W-1:0]  space_left;
    logic              is_empty;
    logic              is_full;
    logic              last;
  } res_t;

endpackage

// ===== rtl/brf_mem.sv =====
module brf_mem
  import brf_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/brf_outreg.sv =====
module brf_outreg
  import brf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cand_vld,
  input  res_t cand,
  output logic cand_rdy,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic vld_r;
  res_t res_r;

  assign cand_rdy = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (cand_rdy) begin
      vld_r <= cand_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_vld && cand_rdy) begin
      res_r <= cand;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/brf_ctrl.sv =====
module brf_ctrl
  import brf_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH),
  localparam int QW = AW + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [DATA_W-1:0]  in_data_in,
  input  logic [CNT_W-1:0]   in_count,
  input  logic [PAT_W-1:0]   in_pattern,
  input  logic [PLEN_W-1:0]  in_pattern_len,
  input  logic               cfg_we,
  input  logic [QSIZE_W-1:0] cfg_wdata,
  output logic [QW-1:0]      qsize,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [DATA_W-1:0]  mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic [DATA_W-1:0]  mem_rdata,
  output logic               cand_vld,
  output res_t               cand,
  input  logic               cand_rdy
);

  localparam int QRST = (DEPTH < QSIZE_HI) ? DEPTH : QSIZE_HI;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]      level_r, level_nxt;
  logic [QW-1:0]      qsize_r, qsize_nxt;
  logic               rdv_r, rdv_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW-1:0]      issued_r, issued_nxt;
  logic [AW-1:0]      seen_r, seen_nxt;
  logic [AW-1:0]      total_r, total_nxt;
  logic               pmode_r, pmode_nxt;
  logic [DATA_W-1:0]  key_r, key_nxt;
  logic [PAT_W-1:0]   pat_r, pat_nxt;
  logic [PLEN_W-1:0]  plen_r, plen_nxt;
  logic [PAT_W-1:0]   win_r, win_nxt;
  logic               ok_r, ok_nxt;
  logic               found_r, found_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;

  logic [QW-1:0]      free_q;
  logic               is_full;
  logic [AW-1:0]      wr_inc, addr_inc, rd_add, n_sel;
  logic [QW-1:0]      rd_sum;
  logic [CNT_W-1:0]   cnt_sat;
  logic [PLEN_W-1:0]  plen_sat;
  logic [QSIZE_W-1:0] qs_clamp;
  logic [PAT_W-1:0]   win_dn, win_sh;
  logic               pat_hit, byte_hit, hit, consume;
  logic               burst_last, scan_last;
  logic [AW-1:0]      pos_pat;

  assign qsize   = qsize_r;
  assign free_q  = qsize_r - QW'(1) - {1'b0, level_r};
  assign is_full = (free_q == '0);

  assign wr_inc   = ({1'b0, wr_idx_r} + QW'(1) == qsize_r) ? '0 : wr_idx_r + AW'(1);
  assign addr_inc = ({1'b0, addr_r} + QW'(1) == qsize_r) ? '0 : addr_r + AW'(1);

  assign cnt_sat  = (in_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : in_count;
  assign plen_sat = (in_pattern_len > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN)
                                                            : in_pattern_len;
  assign n_sel    = (32'(cnt_sat) > 32'(level_r)) ? level_r : AW'(cnt_sat);
  assign rd_sum   = {1'b0, rd_idx_r} + {1'b0, n_sel};
  assign rd_add   = (rd_sum >= qsize_r) ? AW'(rd_sum - qsize_r) : AW'(rd_sum);

  assign qs_clamp = (cfg_wdata < QSIZE_W'(2))      ? QSIZE_W'(2) :
                    (32'(cfg_wdata) > 32'(DEPTH)) ? QSIZE_W'(DEPTH) : cfg_wdata;

  assign burst_last = (seen_r == total_r - AW'(1));
  assign scan_last  = burst_last;
  assign byte_hit   = (mem_rdata == key_r);
  assign pos_pat    = AW'(32'(seen_r) + 32'd1 - 32'(plen_r));
  assign win_dn     = {{DATA_W{1'b0}}, win_r[PAT_W-1:DATA_W]};

  // sliding window: newest byte enters at slot plen-1, older bytes move down
  always_comb begin
    win_sh  = win_r;
    pat_hit = (32'(seen_r) + 32'd1) >= 32'(plen_r);
    for (int d = 0; d < MAX_PATTERN; d++) begin
      if (PLEN_W'(d) + PLEN_W'(1) == plen_r) begin
        win_sh[DATA_W*d +: DATA_W] = mem_rdata;
      end else if (PLEN_W'(d) + PLEN_W'(1) < plen_r) begin
        win_sh[DATA_W*d +: DATA_W] = win_dn[DATA_W*d +: DATA_W];
      end
    end
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (PLEN_W'(j) < plen_r &&
          win_sh[DATA_W*j +: DATA_W] != pat_r[DATA_W*j +: DATA_W]) begin
        pat_hit = 1'b0;
      end
    end
  end

  always_comb begin
    cand.data_out   = (state_r == ST_BURST) ? mem_rdata : '0;
    cand.ok         = (state_r == ST_BURST) ? 1'b1 : ok_r;
    cand.found      = (state_r == ST_BURST) ? 1'b0 : found_r;
    cand.position   = (state_r == ST_BURST) ? '0 : POS_W'(pos_r);
    cand.level      = LVL_W'(level_r);
    cand.space_left = LVL_W'(free_q);
    cand.is_empty   = (level_r == '0);
    cand.is_full    = is_full;
    cand.last       = (state_r == ST_BURST) ? burst_last : 1'b1;
  end

  assign mem_waddr = wr_idx_r;
  assign mem_wdata = in_data_in;
  assign mem_raddr = addr_r;

  always_comb begin
    state_nxt  = state_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    level_nxt  = level_r;
    qsize_nxt  = qsize_r;
    rdv_nxt    = rdv_r;
    addr_nxt   = addr_r;
    issued_nxt = issued_r;
    seen_nxt   = seen_r;
    total_nxt  = total_r;
    pmode_nxt  = pmode_r;
    key_nxt    = key_r;
    pat_nxt    = pat_r;
    plen_nxt   = plen_r;
    win_nxt    = win_r;
    ok_nxt     = ok_r;
    found_nxt  = found_r;
    pos_nxt    = pos_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    cand_vld   = 1'b0;
    in_ready   = 1'b0;
    consume    = 1'b0;
    hit        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EMIT: begin
        cand_vld = 1'b1;
        if (cand_rdy) begin
          in_ready  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_BURST: begin
        if (rdv_r) begin
          cand_vld = 1'b1;
          if (cand_rdy) begin
            consume  = 1'b1;
            seen_nxt = seen_r + AW'(1);
            if (burst_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
        if (issued_r != total_r && (!rdv_r || consume)) begin
          mem_re     = 1'b1;
          addr_nxt   = addr_inc;
          issued_nxt = issued_r + AW'(1);
        end
        rdv_nxt = mem_re || (rdv_r && !consume);
      end
      ST_SCAN: begin
        if (rdv_r) begin
          seen_nxt = seen_r + AW'(1);
          if (pmode_r) begin
            win_nxt = win_sh;
            hit     = pat_hit;
          end else begin
            hit = byte_hit;
          end
          if (hit) begin
            ok_nxt    = 1'b1;
            found_nxt = 1'b1;
            pos_nxt   = pmode_r ? pos_pat : seen_r;
            state_nxt = ST_EMIT;
          end else if (scan_last) begin
            state_nxt = ST_EMIT;
          end
        end
        if (!hit && issued_r != total_r) begin
          mem_re     = 1'b1;
          addr_nxt   = addr_inc;
          issued_nxt = issued_r + AW'(1);
        end
        rdv_nxt = mem_re;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (in_valid && in_ready) begin
      rdv_nxt    = 1'b0;
      issued_nxt = '0;
      seen_nxt   = '0;
      addr_nxt   = rd_idx_r;
      ok_nxt     = 1'b0;
      found_nxt  = 1'b0;
      pos_nxt    = '0;
      state_nxt  = ST_EMIT;
      key_nxt    = in_data_in;
      pat_nxt    = in_pattern;
      plen_nxt   = plen_sat;
      unique case (op_t'(in_kind))
        OP_PUSH: begin
          if (!is_full) begin
            mem_we     = 1'b1;
            wr_idx_nxt = wr_inc;
            level_nxt  = level_r + AW'(1);
            ok_nxt     = 1'b1;
          end
        end
        OP_POP, OP_PEEK: begin
          if (n_sel != '0) begin
            total_nxt = n_sel;
            state_nxt = ST_BURST;
            if (op_t'(in_kind) == OP_POP) begin
              rd_idx_nxt = rd_add;
              level_nxt  = level_r - n_sel;
            end
          end
        end
        OP_FIND: begin
          pmode_nxt = 1'b0;
          total_nxt = level_r;
          if (level_r != '0) begin
            state_nxt = ST_SCAN;
          end
        end
        OP_FINDPAT: begin
          pmode_nxt = 1'b1;
          total_nxt = level_r;
          if (plen_sat != '0 && 32'(plen_sat) <= 32'(level_r)) begin
            state_nxt = ST_SCAN;
          end
        end
        OP_FLUSH: begin
          wr_idx_nxt = '0;
          rd_idx_nxt = '0;
          level_nxt  = '0;
          ok_nxt     = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (cfg_we) begin
      qsize_nxt  = QW'(qs_clamp);
      wr_idx_nxt = '0;
      rd_idx_nxt = '0;
      level_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      level_r  <= '0;
      qsize_r  <= QW'(QRST);
      rdv_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      level_r  <= level_nxt;
      qsize_r  <= qsize_nxt;
      rdv_r    <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    issued_r <= issued_nxt;
    seen_r   <= seen_nxt;
    total_r  <= total_nxt;
    pmode_r  <= pmode_nxt;
    key_r    <= key_nxt;
    pat_r    <= pat_nxt;
    plen_r   <= plen_nxt;
    win_r    <= win_nxt;
    ok_r     <= ok_nxt;
    found_r  <= found_nxt;
    pos_r    <= pos_nxt;
  end

endmodule

// ===== rtl/byte_ring_fifo_with_search.sv =====
// Circular byte FIFO over a DEPTH x 8 single-port-read byte store, holding up to
// queue_size - 1 bytes, with pop/peek bursts and byte or pattern search. One
// operation is in flight at a time. Push, flush and refused operations each
// give a single result. A pop or peek of n bytes delivers one byte per cycle
// while the output side keeps up; a find reads one stored byte per cycle until
// a hit or the last held byte. These rates are set by the store's single read
// port and its registered read data. Every result reports level, free space,
// empty and full as they stand after the whole operation. Writing queue_size
// (register 0, byte address 0) empties the FIFO; do so only while the block is
// idle.
module byte_ring_fifo_with_search
  import brf_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [DATA_W-1:0] in_data_in,
  input  logic [CNT_W-1:0]  in_count,
  input  logic [PAT_W-1:0]  in_pattern,
  input  logic [PLEN_W-1:0] in_pattern_len,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data_out,
  output logic              out_ok,
  output logic              out_found,
  output logic [POS_W-1:0]  out_position,
  output logic [LVL_W-1:0]  out_level,
  output logic [LVL_W-1:0]  out_space_left,
  output logic              out_is_empty,
  output logic              out_is_full,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(DEPTH);

  logic              cfg_we;
  logic [AW:0]       qsize;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  logic              cand_vld, cand_rdy;
  res_t              cand, out_res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_QSIZE);
  assign prdata = (paddr[APB_AW-1:2] == REG_QSIZE) ? APB_DW'(qsize) : '0;

  brf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_data_in     (in_data_in),
    .in_count       (in_count),
    .in_pattern     (in_pattern),
    .in_pattern_len (in_pattern_len),
    .cfg_we         (cfg_we),
    .cfg_wdata      (pwdata[QSIZE_W-1:0]),
    .qsize          (qsize),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .cand_vld       (cand_vld),
    .cand           (cand),
    .cand_rdy       (cand_rdy)
  );

  brf_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  brf_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cand_vld  (cand_vld),
    .cand      (cand),
    .cand_rdy  (cand_rdy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_data_out   = out_res.data_out;
  assign out_ok         = out_res.ok;
  assign out_found      = out_res.found;
  assign out_position   = out_res.position;
  assign out_level      = out_res.level;
  assign out_space_left = out_res.space_left;
  assign out_is_empty   = out_res.is_empty;
  assign out_is_full    = out_res.is_full;
  assign out_last       = out_res.last;

endmodule

// ===== rtl/brf_checker.sv =====
module brf_checker
  import brf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_data_out,
  input logic              out_ok,
  input logic              out_found,
  input logic              out_is_empty,
  input logic              out_is_full,
  input logic              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out) && $stable(out_last))
    else $error("result changed while stalled");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("empty and full together");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_ok && out_last && (out_data_out == '0))
    else $error("search hit not a single ok transfer");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_last && !out_found && (out_data_out == '0))
    else $error("failed operation not a single transfer");

endmodule

bind byte_ring_fifo_with_search brf_checker u_brf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_data_out (out_data_out),
  .out_ok       (out_ok),
  .out_found    (out_found),
  .out_is_empty (out_is_empty),
  .out_is_full  (out_is_full),
  .out_last     (out_last)
);

// ===== sim/byte_ring_fifo_with_search_test.sv =====
`timescale 1ns / 100ps

module byte_ring_fifo_with_search_test;
  import brf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int RING_CELLS     = 1024;
  localparam int STALL_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int RANDOM_PER_PHASE = 17;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic [PAT_W-1:0]  pattern;
    logic [PLEN_W-1:0] plen;
  } fifo_op_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind;
  logic [DATA_W-1:0] in_data_in;
  logic [CNT_W-1:0]  in_count;
  logic [PAT_W-1:0]  in_pattern;
  logic [PLEN_W-1:0] in_pattern_len;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_data_out;
  logic              out_ok;
  logic              out_found;
  logic [POS_W-1:0]  out_position;
  logic [LVL_W-1:0]  out_level;
  logic [LVL_W-1:0]  out_space_left;
  logic              out_is_empty;
  logic              out_is_full;
  logic              out_last;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  byte_ring_fifo_with_search uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0]  ring_bytes [RING_CELLS];
  int unsigned ring_wr;
  int unsigned ring_rd;
  int unsigned ring_len;
  res_t        due_results [$];

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off_req;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned ops_sent;
  int unsigned size_writes;
  int unsigned quiet_cycles;

  function automatic int unsigned held_bytes();
    return (ring_wr >= ring_rd) ? ring_wr - ring_rd : ring_len - ring_rd + ring_wr;
  endfunction

  function automatic logic [7:0] byte_at(int unsigned offset);
    return ring_bytes[(ring_rd + offset) % ring_len];
  endfunction

  function automatic void queue_result(logic [7:0] data, logic ok, logic found,
                                       int unsigned pos, logic last);
    res_t r;
    int unsigned lvl;
    int unsigned room;
    lvl = held_bytes();
    room = ring_len - 1 - lvl;
    r.data_out   = data;
    r.ok         = ok;
    r.found      = found;
    r.position   = POS_W'(pos);
    r.level      = LVL_W'(lvl);
    r.space_left = LVL_W'(room);
    r.is_empty   = (lvl == 0);
    r.is_full    = (room == 0);
    r.last       = last;
    due_results.push_back(r);
  endfunction

  function automatic void apply_fifo_op(fifo_op_t op);
    int unsigned lvl;
    int unsigned n;
    int unsigned plen;
    logic [7:0]  got [MAX_BURST];
    bit          hit;
    bit          done;
    lvl = held_bytes();
    case (op.kind)
      OP_PUSH: begin
        if ((ring_wr + 1) % ring_len == ring_rd) begin
          queue_result(8'h00, 1'b0, 1'b0, 0, 1'b1);
        end else begin
          ring_bytes[ring_wr] = op.data;
          ring_wr = (ring_wr + 1) % ring_len;
          queue_result(8'h00, 1'b1, 1'b0, 0, 1'b1);
        end
      end
      OP_POP, OP_PEEK: begin
        n = (op.count > MAX_BURST) ? MAX_BURST : op.count;
        if (n > lvl) n = lvl;
        if (n == 0) begin
          queue_result(8'h00, 1'b0, 1'b0, 0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) got[i] = byte_at(i);
          if (op.kind == OP_POP) ring_rd = (ring_rd + n) % ring_len;
          for (int i = 0; i < n; i++) queue_result(got[i], 1'b1, 1'b0, 0, i + 1 == n);
        end
      end
      OP_FIND: begin
        done = 1'b0;
        for (int i = 0; i < lvl && !done; i++) begin
          if (byte_at(i) == op.data) begin
            queue_result(8'h00, 1'b1, 1'b1, i, 1'b1);
            done = 1'b1;
          end
        end
        if (!done) queue_result(8'h00, 1'b0, 1'b0, 0, 1'b1);
      end
      OP_FINDPAT: begin
        done = 1'b0;
        plen = (op.plen > MAX_PATTERN) ? MAX_PATTERN : op.plen;
        if (plen != 0 && lvl >= plen) begin
          for (int i = 0; i + plen <= lvl && !done; i++) begin
            hit = 1'b1;
            for (int j = 0; j < plen; j++) begin
              if (byte_at(i + j) != op.pattern[8*j +: 8]) hit = 1'b0;
            end
            if (hit) begin
              queue_result(8'h00, 1'b1, 1'b1, i, 1'b1);
              done = 1'b1;
            end
          end
        end
        if (!done) queue_result(8'h00, 1'b0, 1'b0, 0, 1'b1);
      end
      OP_FLUSH: begin
        ring_wr = 0;
        ring_rd = 0;
        queue_result(8'h00, 1'b1, 1'b0, 0, 1'b1);
      end
      default: queue_result(8'h00, 1'b0, 1'b0, 0, 1'b1);
    endcase
  endfunction

  function automatic fifo_op_t make_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] data,
                                       logic [CNT_W-1:0] count, logic [PAT_W-1:0] pattern,
                                       logic [PLEN_W-1:0] plen);
    fifo_op_t op;
    op.kind    = kind;
    op.data    = data;
    op.count   = count;
    op.pattern = pattern;
    op.plen    = plen;
    return op;
  endfunction

  // held bytes at offset..offset+len-1, junk above
  function automatic logic [PAT_W-1:0] pattern_from_ring(int unsigned offset, int unsigned len);
    logic [PAT_W-1:0] pat;
    pat = {$urandom, $urandom};
    for (int j = 0; j < len; j++) pat[8*j +: 8] = byte_at(offset + j);
    return pat;
  endfunction

  function automatic fifo_op_t random_op();
    fifo_op_t    op;
    int unsigned lvl;
    int unsigned dice;
    int unsigned len;
    lvl = held_bytes();
    op = make_op(OP_PUSH, DATA_W'($urandom), CNT_W'($urandom_range(1, 4)),
                 {$urandom, $urandom}, PLEN_W'($urandom_range(1, MAX_PATTERN)));
    dice = $urandom_range(99);
    if (dice < 10) begin
      op.kind  = KIND_W'($urandom);
      op.count = CNT_W'($urandom);
      op.plen  = PLEN_W'($urandom);
    end else if (dice < 60) begin
      op.kind = OP_PUSH;
    end else if (dice < 70) begin
      op.kind = OP_POP;
      if ($urandom_range(4) == 0) op.count = CNT_W'($urandom_range(1, MAX_BURST));
    end else if (dice < 78) begin
      op.kind  = OP_PEEK;
      op.count = CNT_W'($urandom_range(1, MAX_BURST));
    end else if (dice < 88) begin
      op.kind = OP_FIND;
      if (lvl > 0 && $urandom_range(3) != 0) op.data = byte_at($urandom_range(lvl - 1));
    end else if (dice < 97) begin
      op.kind = OP_FINDPAT;
      if (lvl > 0 && $urandom_range(3) != 0) begin
        len = $urandom_range(1, (lvl < MAX_PATTERN) ? lvl : MAX_PATTERN);
        op.plen    = PLEN_W'(len);
        op.pattern = pattern_from_ring($urandom_range(lvl - len), len);
      end
    end else begin
      op.kind = OP_FLUSH;
    end
    return op;
  endfunction

  task automatic send_op(input fifo_op_t op);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= op.kind;
    in_data_in     <= op.data;
    in_count       <= op.count;
    in_pattern     <= op.pattern;
    in_pattern_len <= op.plen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_fifo_op(op);
    ops_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_queue_size(input logic [APB_DW-1:0] value);
    int unsigned v;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_QSIZE, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = value[QSIZE_W-1:0];
    if (v < 2) v = 2;
    if (v > QSIZE_HI) v = QSIZE_HI;
    ring_len = v;
    ring_wr  = 0;
    ring_rd  = 0;
    size_writes++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 30)
      $display("%0t: result %0d %s got 0x%0h want 0x%0h", $time, results_checked, what,
               got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected transfer, data_out", out_data_out, 0);
      end else begin
        want = due_results.pop_front();
        if (out_data_out !== want.data_out) report_mismatch("data_out", out_data_out, want.data_out);
        if (out_ok !== want.ok) report_mismatch("ok", out_ok, want.ok);
        if (out_found !== want.found) report_mismatch("found", out_found, want.found);
        if (out_position !== want.position) report_mismatch("position", out_position, want.position);
        if (out_level !== want.level) report_mismatch("level", out_level, want.level);
        if (out_space_left !== want.space_left)
          report_mismatch("space_left", out_space_left, want.space_left);
        if (out_is_empty !== want.is_empty) report_mismatch("is_empty", out_is_empty, want.is_empty);
        if (out_is_full !== want.is_full) report_mismatch("is_full", out_is_full, want.is_full);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer in %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int unsigned held;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_LEN; held++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic test_directed_ops();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    // empty fifo
    send_op(make_op(OP_POP, 8'h00, 5'd1, '0, 4'd1));
    send_op(make_op(OP_PEEK, 8'h00, 5'd16, '0, 4'd1));
    send_op(make_op(OP_FIND, 8'h00, 5'd1, '0, 4'd1));
    send_op(make_op(OP_FINDPAT, 8'h00, 5'd1, '0, 4'd1));
    send_op(make_op(KIND_SPARE_LO, 8'hFF, 5'd31, '1, 4'd15));
    send_op(make_op(KIND_SPARE_HI, 8'h00, 5'd0, '0, 4'd0));
    send_op(make_op(OP_PUSH, 8'h00, 5'd1, '0, 4'd1));
    send_op(make_op(OP_PUSH, 8'hFF, 5'd1, '0, 4'd1));
    send_op(make_op(OP_PUSH, 8'h5A, 5'd1, '0, 4'd1));
    send_op(make_op(OP_PUSH, 8'hA5, 5'd1, '0, 4'd1));
    send_op(make_op(OP_PEEK, 8'h00, 5'd0, '0, 4'd1));
    send_op(make_op(OP_PEEK, 8'h00, 5'd31, '0, 4'd1));
    send_op(make_op(OP_FIND, 8'hFF, 5'd1, '0, 4'd1));
    send_op(make_op(OP_FIND, 8'h77, 5'd1, '0, 4'd1));
    send_op(make_op(OP_FINDPAT, 8'h00, 5'd1, 64'hDEAD_BEEF_0000_A55A, 4'd2));
    send_op(make_op(OP_FINDPAT, 8'h00, 5'd1, 64'hDEAD_BEEF_0000_A55A, 4'd0));
    send_op(make_op(OP_FINDPAT, 8'h00, 5'd1, 64'hFFFF_FFFF_A55A_FF00, 4'd15));
    send_op(make_op(OP_POP, 8'h00, 5'd2, '0, 4'd1));
    send_op(make_op(OP_FLUSH, 8'h00, 5'd1, '0, 4'd1));
  endtask

  task automatic test_ring_sizes();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    write_queue_size(32'd0);
    send_op(make_op(OP_PUSH, 8'h11, 5'd1, '0, 4'd1));
    send_op(make_op(OP_PUSH, 8'h22, 5'd1, '0, 4'd1));
    send_op(make_op(OP_POP, 8'h00, 5'd16, '0, 4'd1));
    // upper bits beyond the register width are dropped
    write_queue_size(32'hFFFF_F805);
    repeat (5) send_op(make_op(OP_PUSH, DATA_W'($urandom), 5'd1, '0, 4'd1));
    send_op(make_op(OP_POP, 8'h00, 5'd3, '0, 4'd1));
    repeat (2) send_op(make_op(OP_PUSH, DATA_W'($urandom), 5'd1, '0, 4'd1));
    send_op(make_op(OP_FINDPAT, 8'h00, 5'd1, pattern_from_ring(1, 2), 4'd2));
    send_op(make_op(OP_PEEK, 8'h00, 5'd16, '0, 4'd1));
    write_queue_size(32'd2047);
    send_op(make_op(OP_PUSH, 8'hC3, 5'd1, '0, 4'd1));
    write_queue_size(32'd1);
    send_op(make_op(OP_PUSH, 8'h3C, 5'd1, '0, 4'd1));
    send_op(make_op(OP_PUSH, 8'h3C, 5'd1, '0, 4'd1));
  endtask

  task automatic test_random_traffic();
    int unsigned idle_mix  [4] = '{0, 79, 0, 23};
    int unsigned stall_mix [4] = '{0, 0, 79, 23};
    for (int p = 0; p < 4; p++) begin
      write_queue_size((p == 0) ? QSIZE_HI : $urandom_range(2, 24));
      sender_idle_pct = idle_mix[p];
      recv_stall_pct  = stall_mix[p];
      repeat (RANDOM_PER_PHASE) send_op(random_op());
    end
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    write_queue_size(32'd20);
    hold_off_req = 1'b1;
    repeat (10) send_op(make_op(OP_PUSH, DATA_W'($urandom), 5'd1, '0, 4'd1));
    send_op(make_op(OP_PEEK, 8'h00, 5'd16, '0, 4'd1));
    send_op(make_op(OP_POP, 8'h00, 5'd16, '0, 4'd1));
    wait_drained();
    repeat (4) send_op(random_op());
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = OP_PUSH;
    in_data_in     = '0;
    in_count       = '0;
    in_pattern     = '0;
    in_pattern_len = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    hold_off_req   = 1'b0;
    ring_len       = QSIZE_HI;
    ring_wr        = 0;
    ring_rd        = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_ring_sizes();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d results from %0d operations over %0d ring size writes,",
             results_checked, ops_sent, size_writes);
    $display("with idle/stall phases and a long output hold-off; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
